@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/ep2ke_pkg.sv @@
// ----------------------------------------------------------------------------
// ep2ke_pkg
// shared codes and controller/datapath signal groups for the encoder block
// ----------------------------------------------------------------------------
package ep2ke_pkg;

  // key actions
  localparam logic [1:0] ACT_DOWN = 2'd0;
  localparam logic [1:0] ACT_UP   = 2'd1;
  localparam logic [1:0] ACT_LONG = 2'd2;

  // key codes
  localparam logic [1:0] CODE_RIGHT = 2'd0;
  localparam logic [1:0] CODE_LEFT  = 2'd1;
  localparam logic [1:0] CODE_ENTER = 2'd2;

  // register indexes
  localparam logic CFG_ENABLE     = 1'b0;
  localparam logic CFG_LONG_PRESS = 1'b1;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic emit;    // load the next event into the output register
  } ep2ke_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rot_pend;  // rotation events still to send
    logic btn_pend;  // button event still to send
    logic out_free;  // output register can take an event
  } ep2ke_sts_t;

endpackage

@@ src/ep2ke_ctrl.sv @@
// ----------------------------------------------------------------------------
// ep2ke_ctrl
// sequencer: takes one poll, then steps the datapath through its events
// ----------------------------------------------------------------------------
module ep2ke_ctrl
  import ep2ke_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ep2ke_sts_t sts_i,
  output ep2ke_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    cmd_o.emit   = (state_q == ST_BUSY) && sts_i.out_free &&
                   (sts_i.rot_pend || sts_i.btn_pend);
    state_d      = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!sts_i.rot_pend && !sts_i.btn_pend) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/ep2ke_dp.sv @@
// ----------------------------------------------------------------------------
// ep2ke_dp
// button state, event counters, config registers and output register
// ----------------------------------------------------------------------------
module ep2ke_dp
  import ep2ke_pkg::*;
#(
  parameter int MAX_DELTA  = 31,
  parameter int TIME_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              read_error_i,
  input  logic signed [5:0] rotation_i,
  input  logic              button_level_i,
  input  logic [31:0]       now_ms_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        key_action_o,
  output logic [1:0]        key_code_o,
  output logic              last_event_o,
  input  ep2ke_cmd_t        cmd_i,
  output ep2ke_sts_t        sts_o
);

  localparam int SW = $clog2(MAX_DELTA + 1);
  localparam int CW = SW + 1;
  localparam logic signed [6:0] MAX_POS = 7'(MAX_DELTA);
  localparam logic signed [6:0] MAX_NEG = -7'(MAX_DELTA);

  logic                  enable_q;
  logic [15:0]           long_press_q;
  logic                  was_down_q;
  logic [TIME_WIDTH-1:0] press_time_q;
  logic                  lp_done_q;
  logic [CW-1:0]         rot_cnt_q;
  logic [1:0]            rot_code_q;
  logic                  btn_pend_q;
  logic [1:0]            btn_act_q;
  logic                  out_valid_q;
  logic [1:0]            act_q, act_d;
  logic [1:0]            code_q, code_d;
  logic                  last_q, last_d;

  logic signed [6:0]     rot_ext, rot_sat, rot_mag;
  logic [TIME_WIDTH-1:0] now_t, held;
  logic                  take, press, release_edge, hold, reach;

  // poll decode
  always_comb begin
    rot_ext = {rotation_i[5], rotation_i};
    if (rot_ext > MAX_POS) begin
      rot_sat = MAX_POS;
    end else if (rot_ext < MAX_NEG) begin
      rot_sat = MAX_NEG;
    end else begin
      rot_sat = rot_ext;
    end
    rot_mag      = rot_sat[6] ? -rot_sat : rot_sat;
    now_t        = TIME_WIDTH'(now_ms_i);
    held         = now_t - press_time_q;
    reach        = held >= TIME_WIDTH'(long_press_q);
    take         = cmd_i.accept && enable_q && !read_error_i;
    press        = button_level_i && !was_down_q;
    release_edge = !button_level_i && was_down_q;
    hold         = button_level_i && was_down_q && !lp_done_q;
  end

  // next event
  always_comb begin
    if (rot_cnt_q != '0) begin
      act_d  = rot_cnt_q[0] ? ACT_UP : ACT_DOWN;
      code_d = rot_code_q;
      last_d = (rot_cnt_q == CW'(1)) && !btn_pend_q;
    end else begin
      act_d  = btn_act_q;
      code_d = CODE_ENTER;
      last_d = 1'b1;
    end
  end

  assign sts_o.rot_pend = (rot_cnt_q != '0);
  assign sts_o.btn_pend = btn_pend_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      long_press_q <= LONG_PRESS_RESET;
      was_down_q   <= 1'b0;
      press_time_q <= '0;
      lp_done_q    <= 1'b0;
      rot_cnt_q    <= '0;
      btn_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLE:     enable_q     <= cfg_data_i[0];
          CFG_LONG_PRESS: long_press_q <= cfg_data_i;
          default:        enable_q     <= enable_q;
        endcase
      end
      if (take) begin
        rot_cnt_q  <= {rot_mag[SW-1:0], 1'b0};
        btn_pend_q <= press || release_edge || (hold && reach);
        was_down_q <= button_level_i;
        if (press) begin
          press_time_q <= now_t;
          lp_done_q    <= 1'b0;
        end else if (release_edge) begin
          lp_done_q <= 1'b0;
        end else if (hold && reach) begin
          lp_done_q <= 1'b1;
        end
      end else if (cmd_i.emit) begin
        if (rot_cnt_q != '0) begin
          rot_cnt_q <= rot_cnt_q - CW'(1);
        end else begin
          btn_pend_q <= 1'b0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      rot_code_q <= rot_sat[6] ? CODE_LEFT : CODE_RIGHT;
      btn_act_q  <= press ? ACT_DOWN : (release_edge ? ACT_UP : ACT_LONG);
    end
    if (cmd_i.emit) begin
      act_q  <= act_d;
      code_q <= code_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_action_o = act_q;
  assign key_code_o   = code_q;
  assign last_event_o = last_q;

endmodule

@@ src/encoder_poll_to_key_events.sv @@
// ----------------------------------------------------------------------------
// encoder_poll_to_key_events
// turns rotary encoder polls with a push button into key down/up/long events
// ----------------------------------------------------------------------------
// One poll is taken when the block is idle. A poll that is accepted while the
// block is disabled, or that carries a read error, gives no event and leaves
// the button state alone. Otherwise the saturated rotation count gives one
// down/up pair per detent (right for positive, left for negative), followed by
// at most one enter event: down on a press, up on a release, or a single long
// press once the button has been held for long_press_ms. The last event of a
// poll carries last_event. A poll with n events (0 to 63) is taken, then its
// events pass one at a time through the single output register, which the
// consumer can stall, and then the sequencer returns to idle; input ready
// is high only in idle. Config writes take effect at the clock edge they are
// presented and are meant for idle periods.
// ----------------------------------------------------------------------------
module encoder_poll_to_key_events
  import ep2ke_pkg::*;
#(
  parameter int MAX_DELTA  = 31,  // rotation saturation limit, 1 to 31
  parameter int TIME_WIDTH = 32   // width of the press time and elapsed math
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write port
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  // poll channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              read_error_i,
  input  logic signed [5:0] rotation_i,
  input  logic              button_level_i,
  input  logic [31:0]       now_ms_i,
  // event channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        key_action_o,
  output logic [1:0]        key_code_o,
  output logic              last_event_o
);

  ep2ke_cmd_t cmd;
  ep2ke_sts_t sts;

  // sequencer: idle/busy, issues accept and emit
  ep2ke_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: button tracking, event counters, output register
  ep2ke_dp #(
    .MAX_DELTA  (MAX_DELTA),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .read_error_i   (read_error_i),
    .rotation_i     (rotation_i),
    .button_level_i (button_level_i),
    .now_ms_i       (now_ms_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .key_action_o   (key_action_o),
    .key_code_o     (key_code_o),
    .last_event_o   (last_event_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

@@ src/ep2ke_chk.sv @@
// ----------------------------------------------------------------------------
// ep2ke_chk
// port-level checks on the encoder event block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ep2ke_chk
  import ep2ke_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              read_error_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        key_action_o,
  input logic [1:0]        key_code_o,
  input logic              last_event_o
);

  // stalled event holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(key_action_o) && $stable(key_code_o) && $stable(last_event_o))
  // enter events come after all rotation events
  `ASSERT_IMPL(a_enter_last, clk_i, rst_ni, out_valid_o && (key_code_o == CODE_ENTER), last_event_o)
  // a long press is always an enter event
  `ASSERT_IMPL(a_long_enter, clk_i, rst_ni, out_valid_o && (key_action_o == ACT_LONG), key_code_o == CODE_ENTER)
  // a taken rotation down is followed at once by its up
  `ASSERT_NEXT(a_rot_pair, clk_i, rst_ni, out_valid_o && out_ready_i && (key_action_o == ACT_DOWN) && (key_code_o != CODE_ENTER), out_valid_o && (key_action_o == ACT_UP))
  // a failed read produces no event
  `ASSERT_NEXT(a_err_quiet, clk_i, rst_ni, in_valid_i && in_ready_o && read_error_i && !out_valid_o, !out_valid_o)

endmodule

bind encoder_poll_to_key_events ep2ke_chk u_ep2ke_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .read_error_i (read_error_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .key_action_o (key_action_o),
  .key_code_o   (key_code_o),
  .last_event_o (last_event_o)
);
